/* sv/flds_pkg.sv */
package flds_pkg;

  // field widths fixed by the block's data formats
  localparam int SAMPLE_W    = 16;
  localparam int STEP_W      = 20;
  localparam int LEN_W       = 12;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 20;

  // defaults for the top-level parameters
  localparam int FRAC_BITS_DEF = 16;
  localparam int MAX_FLUSH_DEF = 63;

  // most results one input may cause
  localparam int RESULT_CAP  = 64;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // register reset values
  localparam logic [STEP_W-1:0] STEP_RESET    = 20'd180634;
  localparam logic [LEN_W-1:0]  IN_LEN_RESET  = 12'd882;
  localparam logic [LEN_W-1:0]  OUT_LEN_RESET = 12'd320;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_RATIO    = 2'd0,
    CFG_IN_FRAME_LEN  = 2'd1,
    CFG_OUT_FRAME_LEN = 2'd2
  } cfg_index_t;

  // current register contents
  typedef struct packed {
    logic [STEP_W-1:0] step_ratio;
    logic [LEN_W-1:0]  in_frame_len;
    logic [LEN_W-1:0]  out_frame_len;
  } cfg_t;

  // one classified input, front to back
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [SAMPLE_W-1:0] prev;
    logic                       last;
    logic [LEN_W-1:0]           pos;
  } entry_t;

endpackage

/* sv/flds_in_if.sv */
interface flds_in_if;
  import flds_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

/* sv/flds_out_if.sv */
interface flds_out_if;
  import flds_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       frame_done;

  modport source (output valid, output out_sample, output frame_done, input ready);
  modport sink   (input valid, input out_sample, input frame_done, output ready);
endinterface

/* sv/flds_cfg_if.sv */
interface flds_cfg_if;
  import flds_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/flds_front.sv */
module flds_front (
  input  logic            clk,
  input  logic            rst,
  input  flds_pkg::cfg_t  cfg,
  flds_in_if.sink         sample_ch,
  input  logic            full,
  output logic            push,
  output flds_pkg::entry_t entry
);
  import flds_pkg::*;

  logic [LEN_W-1:0]           frame_position;
  logic signed [SAMPLE_W-1:0] previous_sample;
  logic [LEN_W-1:0]           len_m1;
  logic                       last;

  // frame length clamped to at least two, end-of-frame test
  always_comb begin
    len_m1 = (cfg.in_frame_len < LEN_W'(2)) ? LEN_W'(1) : cfg.in_frame_len - LEN_W'(1);
    last   = frame_position >= len_m1;
  end

  assign sample_ch.ready = !full;
  assign push            = sample_ch.valid && !full;

  // classified entry for the back end
  always_comb begin
    entry.sample = sample_ch.sample_in;
    entry.prev   = previous_sample;
    entry.last   = last;
    entry.pos    = last ? len_m1 : frame_position;
  end

  // frame position and previous sample
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position  <= '0;
      previous_sample <= '0;
    end else if (push) begin
      frame_position  <= last ? '0 : frame_position + LEN_W'(1);
      previous_sample <= sample_ch.sample_in;
    end
  end

endmodule

/* sv/flds_fifo.sv */
module flds_fifo #(
  parameter int DEPTH = flds_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  flds_pkg::entry_t wr_data,
  output logic             full,
  input  logic             pop,
  output flds_pkg::entry_t rd_data,
  output logic             rd_valid
);
  import flds_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full     = count == CNT_W'(DEPTH);
  assign rd_valid = count != '0;
  assign rd_data  = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* sv/flds_back.sv */
module flds_back #(
  parameter int FRAC_BITS = flds_pkg::FRAC_BITS_DEF,
  parameter int MAX_FLUSH = flds_pkg::MAX_FLUSH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  flds_pkg::cfg_t   cfg,
  input  logic             head_valid,
  input  flds_pkg::entry_t head,
  output logic             pop,
  flds_out_if.source       result_ch
);
  import flds_pkg::*;

  localparam int PH_W   = LEN_W + FRAC_BITS;
  localparam int SUM_W  = PH_W + 1;
  localparam int FILL_W = $clog2(MAX_FLUSH + 1);
  localparam int N_W    = $clog2(RESULT_CAP + 1);
  localparam int BW     = SAMPLE_W + FRAC_BITS + 2;

  // output sequencer state
  logic [LEN_W-1:0]  out_index;
  logic [PH_W-1:0]   phase;
  logic [N_W-1:0]    n_count;
  logic [FILL_W-1:0] fills;

  // sequencer decisions
  logic [PH_W-1:0]   one;
  logic [PH_W-1:0]   step_ext;
  logic [PH_W-1:0]   step_eff;
  logic [LEN_W-1:0]  olen;
  logic [LEN_W-1:0]  idx;
  logic [LEN_W-1:0]  idx_next;
  logic [SUM_W-1:0]  phase_sum;
  logic [PH_W-1:0]   phase_next;
  logic [LEN_W-1:0]  out_index_next;
  logic [N_W-1:0]    n_count_next;
  logic [FILL_W-1:0] fills_next;
  logic              can_blend;
  logic              can_fill;
  logic              emit;
  logic              next_emit;
  logic              done;
  logic              issue;
  logic              done_flag;

  // operand stage
  logic                       s1_valid;
  logic signed [SAMPLE_W-1:0] s1_a;
  logic signed [SAMPLE_W-1:0] s1_b;
  logic [FRAC_BITS-1:0]       s1_f;
  logic                       s1_done;
  logic signed [SAMPLE_W-1:0] op_a;
  logic signed [SAMPLE_W-1:0] op_b;
  logic [FRAC_BITS-1:0]       op_f;
  logic                       s1_free;

  // output register
  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       out_done;
  logic                       out_free;

  // blend datapath
  logic signed [SAMPLE_W:0]   diff;
  logic signed [FRAC_BITS:0]  f_s;
  logic signed [BW-1:0]       prod;
  logic signed [BW-1:0]       base;
  logic signed [BW-1:0]       acc;
  logic signed [BW-1:0]       rnd;
  logic signed [BW-1:0]       bias;

  assign out_free = !out_valid || result_ch.ready;
  assign s1_free  = !s1_valid || out_free;

  // next output decision for the entry at the queue head
  always_comb begin
    one      = PH_W'(1) << FRAC_BITS;
    step_ext = PH_W'(cfg.step_ratio);
    step_eff = (step_ext < one) ? one : step_ext;
    olen     = (cfg.out_frame_len == '0) ? LEN_W'(1) : cfg.out_frame_len;

    idx       = phase[PH_W-1:FRAC_BITS];
    can_blend = idx < head.pos;
    can_fill  = head.last && (fills < FILL_W'(MAX_FLUSH));
    emit      = head_valid && (out_index < olen) && (n_count < N_W'(RESULT_CAP)) &&
                (can_blend || can_fill);

    // state after this output, phase saturates at all ones
    phase_sum      = {1'b0, phase} + {1'b0, step_eff};
    phase_next     = phase_sum[PH_W] ? {PH_W{1'b1}} : phase_sum[PH_W-1:0];
    out_index_next = out_index + LEN_W'(1);
    n_count_next   = n_count + N_W'(1);
    fills_next     = can_blend ? fills : fills + FILL_W'(1);
    idx_next       = phase_next[PH_W-1:FRAC_BITS];

    // look ahead: does this entry give one more output
    next_emit = (out_index_next < olen) && (n_count_next < N_W'(RESULT_CAP)) &&
                ((idx_next < head.pos) ||
                 (head.last && (fills_next < FILL_W'(MAX_FLUSH))));
    done      = !next_emit;
    issue     = emit && s1_free;
    pop       = head_valid && (!emit || (s1_free && done));
    done_flag = (out_index == olen - LEN_W'(1)) || (head.last && done);

    // operands: blend, copy of the last sample, or zero past the end
    if (can_blend) begin
      op_a = head.prev;
      op_b = head.sample;
      op_f = phase[FRAC_BITS-1:0];
    end else if (idx == head.pos) begin
      op_a = head.sample;
      op_b = head.sample;
      op_f = '0;
    end else begin
      op_a = '0;
      op_b = '0;
      op_f = '0;
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_index <= '0;
      phase     <= '0;
      n_count   <= '0;
      fills     <= '0;
    end else begin
      if (issue) begin
        out_index <= out_index_next;
        phase     <= phase_next;
        n_count   <= n_count_next;
        fills     <= fills_next;
      end
      if (pop) begin
        n_count <= '0;
        fills   <= '0;
        if (head.last) begin
          out_index <= '0;
          phase     <= '0;
        end
      end
    end
  end

  // operand stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_a    <= op_a;
      s1_b    <= op_b;
      s1_f    <= op_f;
      s1_done <= done_flag;
    end
  end

  // a + (b - a) * f, truncated toward zero
  always_comb begin
    diff = {s1_b[SAMPLE_W-1], s1_b} - {s1_a[SAMPLE_W-1], s1_a};
    f_s  = {1'b0, s1_f};
    prod = diff * f_s;
    base = {{(BW-SAMPLE_W-FRAC_BITS){s1_a[SAMPLE_W-1]}}, s1_a, {FRAC_BITS{1'b0}}};
    acc  = base + prod;
    bias = {{(BW-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};
    rnd  = acc[BW-1] ? acc + bias : acc;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      out_sample <= rnd[FRAC_BITS+SAMPLE_W-1:FRAC_BITS];
      out_done   <= s1_done;
    end
  end

  assign result_ch.valid      = out_valid;
  assign result_ch.out_sample = out_sample;
  assign result_ch.frame_done = out_done;

endmodule

/* sv/framed_linear_downsampler.sv */
// Framed linear downsampler. Signed 16-bit samples enter on sample_ch, one
// transaction per cycle while the four-entry queue between the front and
// back ends has room; the front end only tracks the frame position and the
// previous sample, so it never waits on the arithmetic. The back end is a
// sequencer that issues one output per cycle while result_ch does not stall
// it, and pops each input together with the last output that it causes;
// in steady state with a step of one or more that is at most one output per
// input, and the block keeps one sample per cycle while result_ch does not
// stall. At a frame's last input the sequencer also issues up to MAX_FLUSH
// copy or zero fill outputs, one per cycle unless stalled, during which the
// queue absorbs the next samples. Each output passes an operand register
// and one multiply into the output register. Registers on cfg_ch (0
// step_ratio, 1 in_frame_len, 2 out_frame_len) are taken every cycle and
// must be written only while the block is idle.
module framed_linear_downsampler #(
  parameter int FRAC_BITS = flds_pkg::FRAC_BITS_DEF,
  parameter int MAX_FLUSH = flds_pkg::MAX_FLUSH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  flds_in_if.sink    sample_ch,
  flds_out_if.source result_ch,
  flds_cfg_if.sink   cfg_ch
);
  import flds_pkg::*;

  cfg_t   cfg;
  entry_t push_entry;
  entry_t head;
  logic   push;
  logic   full;
  logic   pop;
  logic   head_valid;

  // configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_ratio    <= STEP_RESET;
      cfg.in_frame_len  <= IN_LEN_RESET;
      cfg.out_frame_len <= OUT_LEN_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_STEP_RATIO:    cfg.step_ratio    <= cfg_ch.data[STEP_W-1:0];
        CFG_IN_FRAME_LEN:  cfg.in_frame_len  <= cfg_ch.data[LEN_W-1:0];
        CFG_OUT_FRAME_LEN: cfg.out_frame_len <= cfg_ch.data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  flds_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .sample_ch (sample_ch),
    .full      (full),
    .push      (push),
    .entry     (push_entry)
  );

  flds_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_data  (push_entry),
    .full     (full),
    .pop      (pop),
    .rd_data  (head),
    .rd_valid (head_valid)
  );

  flds_back #(
    .FRAC_BITS (FRAC_BITS),
    .MAX_FLUSH (MAX_FLUSH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .result_ch  (result_ch)
  );

endmodule
